// ===== src/multi_ring_history_buffer_top_macros.svh =====
// Assertion macros shared by the checker of the multi-ring history buffer.
// Each macro expects a signal named clk, and MRHB_ASSERT also rst_n, in the scope where it is used.
`ifndef MULTI_RING_HISTORY_BUFFER_TOP_MACROS_SVH
`define MULTI_RING_HISTORY_BUFFER_TOP_MACROS_SVH

// Checked on every rising edge outside of reset.
`define MRHB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define MRHB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/mrhb_pkg.sv =====
// Shared types, command codes and default sizes of the multi-ring history buffer.
// Used by every module of the block; depends on nothing.
package mrhb_pkg;

    localparam int DEF_NUM_RINGS    = 4;
    localparam int DEF_RING_DEPTH   = 64;
    localparam int DEF_SAMPLE_WIDTH = 48;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_PEEK  = 2'd1;
    localparam logic [1:0] CMD_DUMP  = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_READ,
        OP_ERROR
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_WAIT
    } back_state_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [2:0]  ring_sel;
        logic [47:0] sample_in;
        logic [6:0]  sample_count;
    } cmd_item_t;

    typedef struct packed {
        logic [47:0] sample_out;
        logic        status;
        logic        last;
    } rsp_item_t;

    typedef struct packed {
        op_t         op;
        logic [2:0]  ring;
        logic [6:0]  count;
        logic [47:0] sample;
    } cmd_entry_t;

endpackage

// ===== src/mrhb_front.sv =====
// Front end: accepts command transactions, drops empty ones and classifies the rest.
// Depends on mrhb_pkg; feeds mrhb_queue.
module mrhb_front #(
    parameter int NUM_RINGS  = mrhb_pkg::DEF_NUM_RINGS,
    parameter int RING_DEPTH = mrhb_pkg::DEF_RING_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  mrhb_pkg::cmd_item_t cmd_item,
    output logic                push,
    output mrhb_pkg::cmd_entry_t push_entry,
    input  logic                full
);

    logic                 valid_reg;
    logic                 valid_next;
    mrhb_pkg::cmd_entry_t entry_reg;
    mrhb_pkg::cmd_entry_t entry_class;
    logic                 keep;
    logic                 load;
    logic [6:0]           sat_count;

    assign cmd_stall  = valid_reg && full;
    assign push       = valid_reg && !full;
    assign push_entry = entry_reg;
    assign load       = cmd_valid && !cmd_stall;

    always_comb
    begin
        sat_count = (32'(cmd_item.sample_count) > 32'(RING_DEPTH)) ?
                    7'(RING_DEPTH) : cmd_item.sample_count;
        entry_class.ring   = cmd_item.ring_sel;
        entry_class.sample = cmd_item.sample_in;
        entry_class.count  = sat_count;
        entry_class.op     = mrhb_pkg::OP_WRITE;
        keep               = 1'b1;
        if (cmd_item.cmd == mrhb_pkg::CMD_NONE)
        begin
            keep = 1'b0;
        end
        else if (32'(cmd_item.ring_sel) >= 32'(NUM_RINGS))
        begin
            entry_class.op = mrhb_pkg::OP_ERROR;
        end
        else
        begin
            unique case (cmd_item.cmd)
                mrhb_pkg::CMD_WRITE:
                begin
                    entry_class.op = mrhb_pkg::OP_WRITE;
                end
                mrhb_pkg::CMD_PEEK:
                begin
                    entry_class.op    = mrhb_pkg::OP_READ;
                    entry_class.count = 7'd1;
                end
                default:
                begin
                    entry_class.op = mrhb_pkg::OP_READ;
                    keep           = (sat_count != 7'd0);
                end
            endcase
        end
    end

    always_comb
    begin
        if (load)
        begin
            valid_next = keep;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            entry_reg <= entry_class;
        end
    end

endmodule

// ===== src/mrhb_queue.sv =====
// Short command queue between the front end and the back end.
// Depends on mrhb_pkg for the entry type and its depth.
module mrhb_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  mrhb_pkg::cmd_entry_t push_entry,
    output logic                 full,
    output logic                 q_valid,
    output mrhb_pkg::cmd_entry_t q_entry,
    input  logic                 pop
);

    mrhb_pkg::cmd_entry_t slots [mrhb_pkg::QUEUE_DEPTH];

    logic [mrhb_pkg::QUEUE_AW-1:0] wr_ptr_reg;
    logic [mrhb_pkg::QUEUE_AW-1:0] wr_ptr_next;
    logic [mrhb_pkg::QUEUE_AW-1:0] rd_ptr_reg;
    logic [mrhb_pkg::QUEUE_AW-1:0] rd_ptr_next;
    logic [mrhb_pkg::QUEUE_AW:0]   count_reg;
    logic [mrhb_pkg::QUEUE_AW:0]   count_next;
    logic                          do_push;
    logic                          do_pop;

    assign full    = (count_reg == (mrhb_pkg::QUEUE_AW + 1)'(mrhb_pkg::QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_entry = slots[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== src/mrhb_back.sv =====
// Back end: sample memory, write positions, fill counts and the response register.
// Depends on mrhb_pkg; takes commands from mrhb_queue.
module mrhb_back #(
    parameter int NUM_RINGS    = mrhb_pkg::DEF_NUM_RINGS,
    parameter int RING_DEPTH   = mrhb_pkg::DEF_RING_DEPTH,
    parameter int SAMPLE_WIDTH = mrhb_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  mrhb_pkg::cmd_entry_t q_entry,
    output logic                 q_pop,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output mrhb_pkg::rsp_item_t  rsp_item
);

    localparam int RING_W    = (NUM_RINGS > 1) ? $clog2(NUM_RINGS) : 1;
    localparam int POS_W     = $clog2(RING_DEPTH);
    localparam int CNT_W     = $clog2(RING_DEPTH + 1);
    localparam int MEM_DEPTH = NUM_RINGS * RING_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    logic [SAMPLE_WIDTH-1:0] mem [MEM_DEPTH];

    mrhb_pkg::back_state_t state_reg;
    mrhb_pkg::back_state_t state_next;

    logic [POS_W-1:0]        wp_reg [NUM_RINGS];
    logic [CNT_W-1:0]        fill_reg [NUM_RINGS];
    logic [RING_W-1:0]       ring_reg;
    logic [RING_W-1:0]       ring_next;
    logic [POS_W-1:0]        pos_reg;
    logic [POS_W-1:0]        pos_next;
    logic [CNT_W-1:0]        remain_reg;
    logic [CNT_W-1:0]        remain_next;
    logic [SAMPLE_WIDTH-1:0] mem_q_reg;
    logic                    hit_reg;
    logic                    last_reg;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    mrhb_pkg::rsp_item_t     out_item_reg;
    mrhb_pkg::rsp_item_t     out_item_next;

    logic [RING_W-1:0]       q_ring;
    logic [CNT_W-1:0]        q_count;
    logic [POS_W-1:0]        cur_wp;
    logic [CNT_W-1:0]        cur_fill;
    logic [POS_W-1:0]        wp_inc;
    logic [CNT_W-1:0]        fill_inc;
    logic [CNT_W:0]          wp_ext;
    logic [CNT_W:0]          cnt_ext;
    logic [CNT_W:0]          start_ext;
    logic [POS_W-1:0]        pos_inc;
    logic [ADDR_W-1:0]       wr_addr;
    logic [ADDR_W-1:0]       rd_addr;
    logic                    out_free;
    logic                    mem_we;
    logic                    mem_re;
    logic                    pos_we;

    assign rsp_valid = out_valid_reg;
    assign rsp_item  = out_item_reg;
    assign out_free  = !out_valid_reg || !rsp_stall;

    always_comb
    begin
        q_ring    = q_entry.ring[RING_W-1:0];
        q_count   = q_entry.count[CNT_W-1:0];
        cur_wp    = wp_reg[q_ring];
        cur_fill  = fill_reg[q_ring];
        wp_inc    = (cur_wp == POS_W'(RING_DEPTH - 1)) ? '0 : cur_wp + 1'b1;
        fill_inc  = (cur_fill == CNT_W'(RING_DEPTH)) ? cur_fill : cur_fill + 1'b1;
        wp_ext    = (CNT_W + 1)'(cur_wp);
        cnt_ext   = (CNT_W + 1)'(q_count);
        start_ext = (wp_ext >= cnt_ext) ? wp_ext - cnt_ext :
                    wp_ext + (CNT_W + 1)'(RING_DEPTH) - cnt_ext;
        pos_inc   = (pos_reg == POS_W'(RING_DEPTH - 1)) ? '0 : pos_reg + 1'b1;
        wr_addr   = ADDR_W'(q_ring) * ADDR_W'(RING_DEPTH) + ADDR_W'(cur_wp);
        rd_addr   = ADDR_W'(ring_reg) * ADDR_W'(RING_DEPTH) + ADDR_W'(pos_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mrhb_pkg::ST_IDLE:
            begin
                if (q_valid && (q_entry.op == mrhb_pkg::OP_READ))
                begin
                    state_next = mrhb_pkg::ST_READ;
                end
            end
            mrhb_pkg::ST_READ:
            begin
                state_next = mrhb_pkg::ST_WAIT;
            end
            mrhb_pkg::ST_WAIT:
            begin
                if (out_free)
                begin
                    state_next = last_reg ? mrhb_pkg::ST_IDLE : mrhb_pkg::ST_READ;
                end
            end
            default:
            begin
                state_next = mrhb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        pos_we         = 1'b0;
        ring_next      = ring_reg;
        pos_next       = pos_reg;
        remain_next    = remain_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        out_item_next  = out_item_reg;
        unique case (state_reg)
            mrhb_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_entry.op)
                        mrhb_pkg::OP_WRITE:
                        begin
                            q_pop  = 1'b1;
                            mem_we = 1'b1;
                            pos_we = 1'b1;
                        end
                        mrhb_pkg::OP_READ:
                        begin
                            q_pop       = 1'b1;
                            ring_next   = q_ring;
                            pos_next    = start_ext[POS_W-1:0];
                            remain_next = q_count;
                        end
                        mrhb_pkg::OP_ERROR:
                        begin
                            if (out_free)
                            begin
                                q_pop                    = 1'b1;
                                out_valid_next           = 1'b1;
                                out_item_next.sample_out = '0;
                                out_item_next.status     = mrhb_pkg::STATUS_RANGE;
                                out_item_next.last       = 1'b1;
                            end
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            mrhb_pkg::ST_READ:
            begin
                mem_re = 1'b1;
            end
            mrhb_pkg::ST_WAIT:
            begin
                if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    out_item_next.sample_out = hit_reg ? 48'(mem_q_reg) : '0;
                    out_item_next.status     = mrhb_pkg::STATUS_OK;
                    out_item_next.last       = last_reg;
                    pos_next                 = pos_inc;
                    remain_next              = remain_reg - 1'b1;
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mrhb_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_RINGS; i++)
            begin
                wp_reg[i]   <= '0;
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (pos_we)
            begin
                wp_reg[q_ring]   <= wp_inc;
                fill_reg[q_ring] <= fill_inc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ring_reg     <= ring_next;
        pos_reg      <= pos_next;
        remain_reg   <= remain_next;
        out_item_reg <= out_item_next;
        if (mem_re)
        begin
            hit_reg  <= (CNT_W'(pos_reg) < fill_reg[ring_reg]);
            last_reg <= (remain_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= SAMPLE_WIDTH'(q_entry.sample);
        end
        if (mem_re)
        begin
            mem_q_reg <= mem[rd_addr];
        end
    end

endmodule

// ===== src/multi_ring_history_buffer_top.sv =====
// Multi-ring history buffer: overwrite-on-full sample rings with peek and dump.
// A write is done by the back end straight from its idle state; a peek or dump steps through
// read and wait states for each sample, one memory read per sample, and holds on rsp_stall.
// The front end accepts one transaction per cycle until the four-entry queue fills.
// Reset clears FSM and pointers; a per-ring fill count makes unwritten entries read zero.
module multi_ring_history_buffer_top #(
    parameter int NUM_RINGS    = mrhb_pkg::DEF_NUM_RINGS,
    parameter int RING_DEPTH   = mrhb_pkg::DEF_RING_DEPTH,
    parameter int SAMPLE_WIDTH = mrhb_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  mrhb_pkg::cmd_item_t cmd_item,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output mrhb_pkg::rsp_item_t rsp_item
);

    logic                 push;
    mrhb_pkg::cmd_entry_t push_entry;
    logic                 full;
    logic                 q_valid;
    mrhb_pkg::cmd_entry_t q_entry;
    logic                 q_pop;

    mrhb_front #(
        .NUM_RINGS  (NUM_RINGS),
        .RING_DEPTH (RING_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd_item   (cmd_item),
        .push       (push),
        .push_entry (push_entry),
        .full       (full)
    );

    mrhb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .q_valid    (q_valid),
        .q_entry    (q_entry),
        .pop        (q_pop)
    );

    mrhb_back #(
        .NUM_RINGS    (NUM_RINGS),
        .RING_DEPTH   (RING_DEPTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .q_pop     (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item)
    );

endmodule

// ===== src/mrhb_checker.sv =====
// Port-level checker for the multi-ring history buffer, bound to the top level.
// Depends on mrhb_pkg and the assertion macros header.
`include "multi_ring_history_buffer_top_macros.svh"

module mrhb_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                cmd_valid,
    input logic                cmd_stall,
    input mrhb_pkg::cmd_item_t cmd_item,
    input logic                rsp_valid,
    input logic                rsp_stall,
    input mrhb_pkg::rsp_item_t rsp_item
);

    `MRHB_ASSERT_ALWAYS(a_no_rsp_in_reset, !rst_n |-> !rsp_valid, "response during reset")

    `MRHB_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item),
                 "stalled response changed")

    `MRHB_ASSERT(a_error_form,
                 rsp_valid && (rsp_item.status == mrhb_pkg::STATUS_RANGE) |->
                 rsp_item.last && (rsp_item.sample_out == '0),
                 "malformed error response")

    `MRHB_ASSERT(a_mid_ok, rsp_valid && !rsp_item.last |-> rsp_item.status == mrhb_pkg::STATUS_OK,
                 "error status inside a dump")

    `MRHB_ASSERT(a_rsp_known, rsp_valid |-> !$isunknown(rsp_item), "unknown bits in a response")

endmodule

bind multi_ring_history_buffer_top mrhb_checker u_checker (.*);

// ===== verif/tb.sv =====
// Self-checking testbench for multi_ring_history_buffer_top: directed and random
// transactions, with a behavioral history predictor and an in-order result checker.
// Depends on mrhb_pkg and the top-level RTL only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_RINGS    = mrhb_pkg::DEF_NUM_RINGS;
    localparam int RING_DEPTH   = mrhb_pkg::DEF_RING_DEPTH;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 48;
    localparam int SETTLE_CYCLES = 24;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cmd_valid;
    logic                cmd_stall;
    mrhb_pkg::cmd_item_t cmd_item;
    logic                rsp_valid;
    logic                rsp_stall = 1'b0;
    mrhb_pkg::rsp_item_t rsp_item;

    logic [47:0]         hist_mem [NUM_RINGS][RING_DEPTH];
    int unsigned         wr_ptr [NUM_RINGS];
    mrhb_pkg::rsp_item_t expected_rsp [$];

    int unsigned send_idle_pct = 0;
    int unsigned rsp_stall_pct = 0;
    int unsigned fail_count = 0;
    int unsigned cycle_cnt = 0;

    multi_ring_history_buffer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic mrhb_pkg::cmd_item_t mk_cmd(logic [1:0] cmd, logic [2:0] ring,
                                                   logic [47:0] sample, logic [6:0] count);
        mrhb_pkg::cmd_item_t it;
        it.cmd          = cmd;
        it.ring_sel     = ring;
        it.sample_in    = sample;
        it.sample_count = count;
        return it;
    endfunction

    function automatic void push_rsp(logic [47:0] sample, logic status, logic last);
        mrhb_pkg::rsp_item_t r;
        r.sample_out = sample;
        r.status     = status;
        r.last       = last;
        expected_rsp.push_back(r);
    endfunction

    function automatic void predict_history(mrhb_pkg::cmd_item_t it);
        int unsigned ring;
        int unsigned ptr;
        int unsigned n;
        int unsigned p;
        if (it.cmd == mrhb_pkg::CMD_NONE)
            return;
        if (it.ring_sel >= NUM_RINGS)
        begin
            push_rsp('0, mrhb_pkg::STATUS_RANGE, 1'b1);
            return;
        end
        ring = it.ring_sel;
        ptr  = wr_ptr[ring];
        case (it.cmd)
            mrhb_pkg::CMD_WRITE:
            begin
                hist_mem[ring][ptr] = it.sample_in;
                wr_ptr[ring] = (ptr + 1) % RING_DEPTH;
            end
            mrhb_pkg::CMD_PEEK:
                push_rsp(hist_mem[ring][(ptr + RING_DEPTH - 1) % RING_DEPTH],
                         mrhb_pkg::STATUS_OK, 1'b1);
            default:
            begin
                n = (it.sample_count > RING_DEPTH) ? RING_DEPTH : it.sample_count;
                p = (ptr + RING_DEPTH - n) % RING_DEPTH;
                for (int unsigned i = 0; i < n; i++)
                begin
                    push_rsp(hist_mem[ring][p], mrhb_pkg::STATUS_OK, (i + 1 == n));
                    p = (p + 1) % RING_DEPTH;
                end
            end
        endcase
    endfunction

    // One transaction; valid stays high into the next send or the final idle.
    task automatic send_cmd(mrhb_pkg::cmd_item_t it);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_item  <= it;
        do
            @(posedge clk);
        while (cmd_stall);
        predict_history(it);
    endtask

    task automatic wait_drain();
        cmd_valid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin : rsp_check
        mrhb_pkg::rsp_item_t exp_r;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp.size() == 0)
                begin
                    $error("unexpected result: sample_out %h status %b last %b",
                           rsp_item.sample_out, rsp_item.status, rsp_item.last);
                    fail_count++;
                end
                else
                begin
                    exp_r = expected_rsp.pop_front();
                    if (rsp_item.sample_out !== exp_r.sample_out)
                    begin
                        $error("sample_out: expected %h, actual %h",
                               exp_r.sample_out, rsp_item.sample_out);
                        fail_count++;
                    end
                    if (rsp_item.status !== exp_r.status)
                    begin
                        $error("status: expected %b, actual %b", exp_r.status, rsp_item.status);
                        fail_count++;
                    end
                    if (rsp_item.last !== exp_r.last)
                    begin
                        $error("last: expected %b, actual %b", exp_r.last, rsp_item.last);
                        fail_count++;
                    end
                end
            end
            rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
        end
    end

    task automatic test_reset_contents();
        send_cmd(mk_cmd(mrhb_pkg::CMD_PEEK, 3'd0, 48'h0, 7'd0));
        send_cmd(mk_cmd(mrhb_pkg::CMD_DUMP, 3'd1, 48'h0, 7'd3));
        send_cmd(mk_cmd(mrhb_pkg::CMD_DUMP, 3'd2, 48'h0, 7'd64));
    endtask

    task automatic test_field_extremes();
        send_cmd(mk_cmd(mrhb_pkg::CMD_WRITE, 3'd0, 48'hFFFF_FFFF_FFFF, 7'd127));
        send_cmd(mk_cmd(mrhb_pkg::CMD_WRITE, 3'd0, 48'h0, 7'd0));
        send_cmd(mk_cmd(mrhb_pkg::CMD_PEEK, 3'd0, 48'hFFFF_FFFF_FFFF, 7'd0));
        send_cmd(mk_cmd(mrhb_pkg::CMD_WRITE, 3'd3, 48'hA5A5_5A5A_C3C3, 7'd0));
        send_cmd(mk_cmd(mrhb_pkg::CMD_PEEK, 3'd3, 48'h0, 7'd127));
        send_cmd(mk_cmd(mrhb_pkg::CMD_DUMP, 3'd0, 48'h0, 7'd0));
        send_cmd(mk_cmd(mrhb_pkg::CMD_DUMP, 3'd0, 48'h0, 7'd1));
        send_cmd(mk_cmd(mrhb_pkg::CMD_DUMP, 3'd0, 48'h0, 7'd2));
        send_cmd(mk_cmd(mrhb_pkg::CMD_DUMP, 3'd0, 48'h0, 7'd64));
        send_cmd(mk_cmd(mrhb_pkg::CMD_DUMP, 3'd3, 48'hFFFF_FFFF_FFFF, 7'd127));
    endtask

    task automatic test_out_of_range();
        send_cmd(mk_cmd(mrhb_pkg::CMD_WRITE, 3'd4, 48'hFFFF_FFFF_FFFF, 7'd5));
        send_cmd(mk_cmd(mrhb_pkg::CMD_PEEK, 3'd7, 48'h0, 7'd0));
        send_cmd(mk_cmd(mrhb_pkg::CMD_DUMP, 3'd5, 48'h0, 7'd64));
        send_cmd(mk_cmd(mrhb_pkg::CMD_DUMP, 3'd6, 48'h0, 7'd0));
        send_cmd(mk_cmd(mrhb_pkg::CMD_PEEK, 3'd0, 48'h0, 7'd0));
    endtask

    task automatic test_unused_command();
        send_cmd(mk_cmd(mrhb_pkg::CMD_NONE, 3'd0, 48'h1234_5678_9ABC, 7'd10));
        send_cmd(mk_cmd(mrhb_pkg::CMD_NONE, 3'd7, 48'hFFFF_FFFF_FFFF, 7'd127));
        send_cmd(mk_cmd(mrhb_pkg::CMD_PEEK, 3'd0, 48'h0, 7'd0));
    endtask

    // Writes dominate and ring 0 is favored, so that ring gathers the most history over the run.
    task automatic test_random_traffic(int unsigned idle_pct, int unsigned stall_pct);
        mrhb_pkg::cmd_item_t it;
        int unsigned         sent;
        int unsigned         pick;
        send_idle_pct = idle_pct;
        rsp_stall_pct = stall_pct;
        sent = 0;
        while (sent < PHASE_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 62)
                it.cmd = mrhb_pkg::CMD_WRITE;
            else if (pick < 74)
                it.cmd = mrhb_pkg::CMD_PEEK;
            else if (pick < 95)
                it.cmd = mrhb_pkg::CMD_DUMP;
            else
                it.cmd = mrhb_pkg::CMD_NONE;
            pick = $urandom_range(0, 99);
            if (pick < 50)
                it.ring_sel = 3'd0;
            else if (pick < 92)
                it.ring_sel = 3'($urandom_range(1, NUM_RINGS - 1));
            else
                it.ring_sel = 3'($urandom_range(NUM_RINGS, 7));
            pick = $urandom_range(0, 99);
            if (pick < 5)
                it.sample_in = '0;
            else if (pick < 10)
                it.sample_in = '1;
            else
                it.sample_in = {16'($urandom), 32'($urandom)};
            pick = $urandom_range(0, 99);
            if (pick < 70)
                it.sample_count = 7'($urandom_range(0, 8));
            else if (pick < 90)
                it.sample_count = 7'($urandom_range(9, 64));
            else
                it.sample_count = 7'($urandom_range(65, 127));
            send_cmd(it);
            if (it.cmd != mrhb_pkg::CMD_NONE)
                sent++;
        end
        wait_drain();
    endtask

    initial
    begin
        for (int r = 0; r < NUM_RINGS; r++)
        begin
            wr_ptr[r] = 0;
            for (int d = 0; d < RING_DEPTH; d++)
                hist_mem[r][d] = '0;
        end
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd_item  = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_contents();
        test_field_extremes();
        test_out_of_range();
        test_unused_command();
        wait_drain();

        test_random_traffic(0, 0);
        test_random_traffic(56, 0);
        test_random_traffic(0, 56);
        test_random_traffic(23, 23);

        send_idle_pct = 0;
        rsp_stall_pct = 23;
        send_cmd(mk_cmd(mrhb_pkg::CMD_DUMP, 3'd0, 48'h0, 7'd64));
        send_cmd(mk_cmd(mrhb_pkg::CMD_DUMP, 3'd0, 48'h0, 7'd100));
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0 && expected_rsp.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+src
src/mrhb_pkg.sv
src/mrhb_front.sv
src/mrhb_queue.sv
src/mrhb_back.sv
src/multi_ring_history_buffer_top.sv
src/mrhb_checker.sv
verif/tb.sv
